/* hw/rtl/hcbd_pkg.sv */
// Types, constants and helpers shared by the chunked body decoder.
`default_nettype none

package hcbd_pkg;

   // decoder phase
   typedef enum logic [3:0] {
      PH_SIZE       = 4'd0,
      PH_SIZE_LF    = 4'd1,
      PH_DATA       = 4'd2,
      PH_DATA_CR    = 4'd3,
      PH_DATA_LF    = 4'd4,
      PH_TRAILER    = 4'd5,
      PH_TRAILER_LF = 4'd6,
      PH_DONE       = 4'd7,
      PH_ERROR      = 4'd8
   } phase_type;

   // result status codes
   localparam logic [1:0] STATUS_RUNNING = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   localparam int unsigned DEF_MAX_SIZE_DIGITS = 16;
   localparam int unsigned DEF_LENGTH_BITS     = 24;

   localparam int unsigned LIMIT_W      = 24;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'hA0_0000;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // {is_hex, nibble}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/http_chunked_body_decoder_unit.sv */
// Chunked transfer body decoder: one body byte in, one result word out.
//
//  port group | dir | words                                  | flow
//  req_*      | in  | in_byte, first_byte, end_of_input      | valid / stall
//  rsp_*      | out | out_byte, payload_valid, status, length | valid / stall
//  csr_*      | in  | body_limit (24 bit)                    | write enable
//
// One byte per clock unless the output stalls. The cycle is set by the
// size-line check at LF: a 32-bit limit subtract feeding a size-wide compare.
// Reset (synchronous) clears the decoder to the start of a size line and loads
// the default body limit; no clearing pass. A stalled result holds in the
// output register; input is stalled only while that register is full and held.
`default_nettype none

module http_chunked_body_decoder_unit
   import hcbd_pkg::*;
#(
   parameter int unsigned MAX_SIZE_DIGITS = DEF_MAX_SIZE_DIGITS,
   parameter int unsigned LENGTH_BITS     = DEF_LENGTH_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_first_byte,
   input  wire logic               req_end_of_input,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [7:0]         rsp_out_byte,
   output      logic               rsp_payload_valid,
   output      logic [1:0]         rsp_status,
   output      logic [23:0]        rsp_body_length,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data
);

   localparam int unsigned SIZE_BITS = 4 * MAX_SIZE_DIGITS;
   localparam int unsigned DCNT_W    = $clog2(MAX_SIZE_DIGITS + 1);
   localparam int unsigned CMP_W     = (SIZE_BITS > 32) ? SIZE_BITS : 32;
   localparam logic [31:0] LEN_MAX   = 32'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [DCNT_W-1:0] DCNT_MAX = DCNT_W'(MAX_SIZE_DIGITS);

   // decoder state
   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   size_ff, size_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic [SIZE_BITS-1:0]   left_ff, left_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic                   line_empty_ff, line_empty_in;
   logic [LIMIT_W-1:0]     limit_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_pv_ff, rsp_pv_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [23:0]            rsp_len_ff, rsp_len_in;

   logic                   accept;

   // state as seen by this byte (first_byte restarts the body)
   phase_type              cur_phase;
   logic [SIZE_BITS-1:0]   cur_size;
   logic [DCNT_W-1:0]      cur_dcnt;
   logic [SIZE_BITS-1:0]   cur_left;
   logic [LENGTH_BITS-1:0] cur_total;
   logic                   cur_line_empty;

   logic [4:0]             hex;
   logic                   is_cr, is_lf;
   logic                   digit_ok;
   logic                   size_zero;
   logic                   left_last;
   logic [31:0]            limit32, lim32, total32, room32;
   logic                   over_limit;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign cur_phase      = req_first_byte ? PH_SIZE : phase_ff;
   assign cur_size       = req_first_byte ? '0 : size_ff;
   assign cur_dcnt       = req_first_byte ? '0 : dcnt_ff;
   assign cur_left       = req_first_byte ? '0 : left_ff;
   assign cur_total      = req_first_byte ? '0 : total_ff;
   assign cur_line_empty = req_first_byte ? 1'b1 : line_empty_ff;

   assign hex       = hex_digit(req_in_byte);
   assign is_cr     = (req_in_byte == CHAR_CR);
   assign is_lf     = (req_in_byte == CHAR_LF);
   assign digit_ok  = hex[4] && (cur_dcnt < DCNT_MAX);
   assign size_zero = (cur_size == '0);
   assign left_last = (cur_left <= SIZE_BITS'(1));

   // limit clamps to what the length counter can hold
   assign limit32    = 32'(limit_ff);
   assign lim32      = (limit32 > LEN_MAX) ? LEN_MAX : limit32;
   assign total32    = 32'(cur_total);
   assign room32     = lim32 - total32;
   assign over_limit = (total32 > lim32) || (CMP_W'(cur_size) > CMP_W'(room32));

   // next phase
   always_comb begin
      phase_in = cur_phase;
      case (cur_phase)
         PH_SIZE: begin
            if (is_cr) begin
               phase_in = (cur_dcnt == '0) ? PH_ERROR : PH_SIZE_LF;
            end else if (!digit_ok) begin
               phase_in = PH_ERROR;
            end
         end
         PH_SIZE_LF: begin
            if (!is_lf) begin
               phase_in = PH_ERROR;
            end else if (size_zero) begin
               phase_in = PH_TRAILER;
            end else if (over_limit) begin
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (left_last) phase_in = PH_DATA_CR;
         end
         PH_DATA_CR:    phase_in = is_cr ? PH_DATA_LF : PH_ERROR;
         PH_DATA_LF:    phase_in = is_lf ? PH_SIZE : PH_ERROR;
         PH_TRAILER: begin
            if (is_cr) phase_in = PH_TRAILER_LF;
         end
         PH_TRAILER_LF: begin
            if (is_lf) begin
               phase_in = cur_line_empty ? PH_DONE : PH_TRAILER;
            end else if (!is_cr) begin
               phase_in = PH_TRAILER;
            end
         end
         PH_DONE:       phase_in = PH_DONE;
         PH_ERROR:      phase_in = PH_ERROR;
         default:       phase_in = PH_ERROR;
      endcase
      if (req_end_of_input && phase_in != PH_DONE) phase_in = PH_ERROR;
   end

   // datapath and result word
   always_comb begin
      size_in       = cur_size;
      dcnt_in       = cur_dcnt;
      left_in       = cur_left;
      total_in      = cur_total;
      line_empty_in = cur_line_empty;
      rsp_pv_in     = 1'b0;
      case (cur_phase)
         PH_SIZE: begin
            if (!is_cr && digit_ok) begin
               size_in = (cur_size << 4) | SIZE_BITS'(hex[3:0]);
               dcnt_in = DCNT_W'(cur_dcnt + 1'b1);
            end
         end
         PH_SIZE_LF: begin
            if (is_lf) begin
               if (size_zero) begin
                  line_empty_in = 1'b1;
               end else if (!over_limit) begin
                  left_in = cur_size;
               end
            end
         end
         PH_DATA: begin
            rsp_pv_in = 1'b1;
            total_in  = LENGTH_BITS'(cur_total + 1'b1);
            if (cur_left != '0) left_in = cur_left - 1'b1;
         end
         PH_DATA_LF: begin
            if (is_lf) begin
               size_in = '0;
               dcnt_in = '0;
            end
         end
         PH_TRAILER: begin
            if (!is_cr) line_empty_in = 1'b0;
         end
         PH_TRAILER_LF: begin
            line_empty_in = is_lf;
         end
         default: ;
      endcase

      case (phase_in)
         PH_DONE:  rsp_status_in = STATUS_DONE;
         PH_ERROR: rsp_status_in = STATUS_ERROR;
         default:  rsp_status_in = STATUS_RUNNING;
      endcase
      rsp_byte_in = rsp_pv_in ? req_in_byte : 8'd0;
      rsp_len_in  = 24'(32'(total_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         size_ff       <= '0;
         dcnt_ff       <= '0;
         left_ff       <= '0;
         total_ff      <= '0;
         line_empty_ff <= 1'b1;
         limit_ff      <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (accept) begin
            phase_ff      <= phase_in;
            size_ff       <= size_in;
            dcnt_ff       <= dcnt_in;
            left_ff       <= left_in;
            total_ff      <= total_in;
            line_empty_ff <= line_empty_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= rsp_byte_in;
         rsp_pv_ff     <= rsp_pv_in;
         rsp_status_ff <= rsp_status_in;
         rsp_len_ff    <= rsp_len_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_payload_valid = rsp_pv_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_body_length   = rsp_len_ff;

   // a chunk in flight always has bytes left
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != '0)
      else $error("data phase with no bytes left");

   a_dcnt_max: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= DCNT_MAX)
      else $error("size digit count overran");

   // done is sticky until a new body starts
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE && !(accept && req_first_byte) |=> phase_ff == PH_DONE)
      else $error("left done without restart");

   a_payload_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pv_ff |-> rsp_status_ff != STATUS_DONE)
      else $error("payload word reported done");

endmodule

`default_nettype wire

/* dv/tb_http_chunked_body_decoder_unit.sv */
// Testbench for the chunked body decoder: directed rows, random bodies, scoreboard.
`timescale 1ns / 100ps

module tb_http_chunked_body_decoder_unit;
   import hcbd_pkg::*;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       first_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        payload_valid;
      logic [1:0]  status;
      logic [23:0] body_length;
   } rsp_word_type;

   // typed rows carry their own expected word, all others use the decoder model
   typedef struct packed {
      req_word_type w;
      logic         typed;
      rsp_word_type want;
   } stim_word_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_in_byte;
   logic                req_first_byte;
   logic                req_end_of_input;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_out_byte;
   logic                rsp_payload_valid;
   logic [1:0]          rsp_status;
   logic [23:0]         rsp_body_length;
   logic                csr_wr_en;
   logic [LIMIT_W-1:0]  csr_wr_data;

   logic                drv_typed;
   rsp_word_type        drv_want;

   stim_word_type       body_q[$];
   stim_word_type       directed_q[$];
   rsp_word_type        result_q[$];
   int                  mismatch_count = 0;

   // decoder model state
   phase_type           dec_phase;
   logic [63:0]         dec_size;
   logic [4:0]          dec_digits;
   logic [63:0]         dec_left;
   logic [23:0]         dec_total;
   logic                dec_line_empty;
   logic [23:0]         dec_limit;

   int                  stall_mode = 0;
   int                  mode_cycles = 0;

   http_chunked_body_decoder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_first_byte    (req_first_byte),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_payload_valid (rsp_payload_valid),
      .rsp_status        (rsp_status),
      .rsp_body_length   (rsp_body_length),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void restart_decoder();
      dec_phase      = PH_SIZE;
      dec_size       = '0;
      dec_digits     = '0;
      dec_left       = '0;
      dec_total      = '0;
      dec_line_empty = 1'b1;
   endfunction

   function automatic rsp_word_type decode_byte(input logic [7:0] c, input logic fb,
                                                input logic eoi);
      rsp_word_type r;
      logic         is_hex;
      logic [3:0]   nib;
      logic [23:0]  room;
      r      = '0;
      is_hex = 1'b0;
      nib    = 4'd0;
      if (fb) restart_decoder();
      if (c >= "0" && c <= "9") begin
         is_hex = 1'b1;
         nib    = 4'(c - "0");
      end else if (c >= "A" && c <= "F") begin
         is_hex = 1'b1;
         nib    = 4'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "f") begin
         is_hex = 1'b1;
         nib    = 4'(c - "a" + 8'd10);
      end
      case (dec_phase)
         PH_SIZE: begin
            if (c == CHAR_CR) begin
               dec_phase = (dec_digits == 0) ? PH_ERROR : PH_SIZE_LF;
            end else if (!is_hex || dec_digits >= DEF_MAX_SIZE_DIGITS) begin
               dec_phase = PH_ERROR;
            end else begin
               dec_size   = {dec_size[59:0], nib};
               dec_digits = dec_digits + 5'd1;
            end
         end
         PH_SIZE_LF: begin
            room = dec_limit - dec_total;
            if (c != CHAR_LF) begin
               dec_phase = PH_ERROR;
            end else if (dec_size == 0) begin
               dec_line_empty = 1'b1;
               dec_phase      = PH_TRAILER;
            end else if (dec_total > dec_limit || dec_size > {40'd0, room}) begin
               dec_phase = PH_ERROR;
            end else begin
               dec_left  = dec_size;
               dec_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            r.payload_valid = 1'b1;
            r.out_byte      = c;
            dec_total       = dec_total + 24'd1;
            if (dec_left != 0) dec_left = dec_left - 64'd1;
            if (dec_left == 0) dec_phase = PH_DATA_CR;
         end
         PH_DATA_CR: dec_phase = (c == CHAR_CR) ? PH_DATA_LF : PH_ERROR;
         PH_DATA_LF: begin
            if (c == CHAR_LF) begin
               dec_size   = '0;
               dec_digits = '0;
               dec_phase  = PH_SIZE;
            end else begin
               dec_phase = PH_ERROR;
            end
         end
         PH_TRAILER: begin
            if (c == CHAR_CR) dec_phase = PH_TRAILER_LF;
            else dec_line_empty = 1'b0;
         end
         PH_TRAILER_LF: begin
            if (c == CHAR_LF) begin
               if (dec_line_empty) begin
                  dec_phase = PH_DONE;
               end else begin
                  dec_line_empty = 1'b1;
                  dec_phase      = PH_TRAILER;
               end
            end else begin
               // CR CR keeps waiting for LF; anything else is line content
               dec_line_empty = 1'b0;
               if (c != CHAR_CR) dec_phase = PH_TRAILER;
            end
         end
         PH_DONE: ;
         default: dec_phase = PH_ERROR;
      endcase
      if (eoi && dec_phase != PH_DONE) dec_phase = PH_ERROR;
      if (dec_phase == PH_DONE) r.status = STATUS_DONE;
      else if (dec_phase == PH_ERROR) r.status = STATUS_ERROR;
      else r.status = STATUS_RUNNING;
      r.body_length = dec_total;
      return r;
   endfunction

   task automatic add_row(input logic [7:0] c, input logic fb, input logic eoi,
                          input logic typed, input logic pv, input logic [1:0] st,
                          input logic [23:0] len);
      stim_word_type s;
      s.w.in_byte            = c;
      s.w.first_byte         = fb;
      s.w.end_of_input       = eoi;
      s.typed                = typed;
      s.want.out_byte        = pv ? c : 8'h00;
      s.want.payload_valid   = pv;
      s.want.status          = st;
      s.want.body_length     = len;
      directed_q.push_back(s);
   endtask

   task automatic push_byte(input logic [7:0] c);
      stim_word_type s;
      s           = '0;
      s.w.in_byte = c;
      body_q.push_back(s);
   endtask

   task automatic push_size_line(input logic [63:0] val, input int ndig);
      int         j;
      logic [3:0] nib;
      for (j = ndig - 1; j >= 0; j--) begin
         nib = (j < 16) ? val[4*j +: 4] : 4'd0;
         if (nib < 10) push_byte(8'h30 + nib);
         else push_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10);
      end
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endtask

   // one chunked body, mostly well formed, sometimes damaged or replaced by noise
   task automatic gen_body();
      int            start, nchunks, nlines, len, idx, k, j, ndig;
      logic [63:0]   val;
      bit            dead;
      stim_word_type s;
      start = body_q.size();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            s                  = '0;
            s.w.in_byte        = 8'($urandom);
            s.w.first_byte     = 1'($urandom);
            s.w.end_of_input   = ($urandom_range(0, 3) == 0);
            body_q.push_back(s);
         end
      end else begin
         dead    = 1'b0;
         nchunks = $urandom_range(0, 3);
         for (k = 0; k < nchunks && !dead; k++) begin
            case ($urandom_range(0, 15))
               0: begin
                  // huge size, trips the limit at LF
                  val  = {$urandom, $urandom};
                  ndig = 16;
                  dead = 1'b1;
               end
               1: begin
                  val  = 64'($urandom_range(1, 6));
                  ndig = 17;
                  dead = 1'b1;
               end
               default: begin
                  val  = 64'($urandom_range(1, 12));
                  ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 16) : 1;
               end
            endcase
            push_size_line(val, ndig);
            if (!dead) begin
               len = int'(val);
               repeat (len) push_byte(8'($urandom));
               push_byte(CHAR_CR);
               push_byte(CHAR_LF);
            end
         end
         if (!dead) begin
            push_size_line(64'd0, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 16) : 1);
            nlines = $urandom_range(0, 2);
            repeat (nlines) begin
               len = $urandom_range(1, 6);
               for (j = 0; j < len; j++) begin
                  if (j > 0 && $urandom_range(0, 9) == 0) push_byte(CHAR_CR);
                  push_byte(8'($urandom_range(8'h20, 8'h7E)));
               end
               push_byte(CHAR_CR);
               push_byte(CHAR_LF);
            end
            push_byte(CHAR_CR);
            push_byte(CHAR_LF);
            if ($urandom_range(0, 1)) begin
               s                = body_q[body_q.size() - 1];
               s.w.end_of_input = 1'b1;
               body_q[body_q.size() - 1] = s;
            end else if ($urandom_range(0, 2) == 0) begin
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            end
         end
         if ($urandom_range(0, 5) == 0) begin
            idx = $urandom_range(start, body_q.size() - 1);
            s   = body_q[idx];
            if ($urandom_range(0, 1)) begin
               s.w.in_byte = 8'($urandom);
            end else begin
               // cut the body short
               while (body_q.size() > idx + 1) void'(body_q.pop_back());
               s.w.end_of_input = 1'b1;
            end
            body_q[idx] = s;
         end
         s              = body_q[start];
         s.w.first_byte = 1'b1;
         body_q[start]  = s;
      end
   endtask

   task automatic send_queued();
      int            burst, gap;
      stim_word_type s;
      while (body_q.size() != 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && body_q.size() != 0) begin
            s = body_q.pop_front();
            req_valid        <= 1'b1;
            req_in_byte      <= s.w.in_byte;
            req_first_byte   <= s.w.first_byte;
            req_end_of_input <= s.w.end_of_input;
            drv_typed        <= s.typed;
            drv_want         <= s.want;
            @(posedge clock);
            while (req_stall) @(posedge clock);
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (result_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // receiver: alternates free-running, light random and heavy stall modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode  = $urandom_range(0, 2);
            mode_cycles = $urandom_range(20, 200);
         end else begin
            mode_cycles = mode_cycles - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type pred;
      if (reset) begin
         restart_decoder();
         dec_limit = LIMIT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("result word with nothing expected: status %0d length %0d",
                      rsp_status, rsp_body_length);
               mismatch_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %02h, got %02h", want.out_byte, rsp_out_byte);
                  mismatch_count++;
               end
               if (rsp_payload_valid !== want.payload_valid) begin
                  $error("payload_valid: expected %0b, got %0b",
                         want.payload_valid, rsp_payload_valid);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_body_length !== want.body_length) begin
                  $error("body_length: expected %0d, got %0d",
                         want.body_length, rsp_body_length);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pred = decode_byte(req_in_byte, req_first_byte, req_end_of_input);
            result_q.push_back(drv_typed ? drv_want : pred);
         end
         if (csr_wr_en) dec_limit = csr_wr_data;
      end
   end

   initial begin
      int ph, i;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_in_byte      <= 8'h00;
      req_first_byte   <= 1'b0;
      req_end_of_input <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      drv_typed        <= 1'b0;
      drv_want         <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      //       byte     first eoi typed pv  status          length
      add_row("2",      1, 0, 1, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_CR,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_LF,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(8'h00,    0, 0, 1, 1, STATUS_RUNNING, 24'd1);
      add_row(8'hFF,    0, 0, 1, 1, STATUS_RUNNING, 24'd2);
      add_row(CHAR_CR,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_LF,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row("0",      0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_CR,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_LF,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row("X",      0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_CR,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_LF,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_CR,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_LF,  0, 0, 1, 0, STATUS_DONE,    24'd2);
      add_row("Z",      0, 0, 1, 0, STATUS_DONE,    24'd2);
      add_row("g",      1, 0, 1, 0, STATUS_ERROR,   24'd0);
      add_row("A",      0, 0, 1, 0, STATUS_ERROR,   24'd0);
      add_row(CHAR_CR,  1, 0, 1, 0, STATUS_ERROR,   24'd0);
      add_row("f",      1, 1, 1, 0, STATUS_ERROR,   24'd0);
      add_row("a",      1, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row(CHAR_CR,  0, 0, 0, 0, STATUS_RUNNING, 24'd0);
      add_row("x",      0, 0, 1, 0, STATUS_ERROR,   24'd0);
      for (i = 0; i < directed_q.size(); i++) body_q.push_back(directed_q[i]);

      for (ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            wait_drained();
            csr_wr_en <= 1'b1;
            case (ph)
               1: csr_wr_data <= 24'd0;
               2: csr_wr_data <= 24'hFF_FFFF;
               3: csr_wr_data <= 24'($urandom_range(1, 30));
               4: csr_wr_data <= 24'($urandom);
               default: csr_wr_data <= 24'd10;
            endcase
            @(posedge clock);
            csr_wr_en <= 1'b0;
         end
         while (body_q.size() < 115) gen_body();
         send_queued();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && result_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #500000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* http_chunked_body_decoder_unit.f */
hw/rtl/hcbd_pkg.sv
hw/rtl/http_chunked_body_decoder_unit.sv
dv/tb_http_chunked_body_decoder_unit.sv
